// ===== rtl/core/ctb_pkg.sv =====
package ctb_pkg;

    localparam int NUM_ARGS = 5;
    localparam int Q_DEPTH  = 2;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_DUMP   = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam int S_DATA_W = 272;
    localparam int M_DATA_W = 240;

    typedef struct packed {
        logic [31:0]                 tstamp;
        logic [7:0]                  cpu;
        logic [NUM_ARGS-1:0][31:0]   args;
        logic [31:0]                 tag;
    } entry_t;

    typedef struct packed {
        logic        is_query;
        logic        is_search;
        logic [2:0]  sel;
        logic [31:0] match;
        entry_t      entry;
    } cmd_t;

endpackage

// ===== rtl/core/ctb_front.sv =====
module ctb_front
    import ctb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_data,
    input  logic                q_full,
    output logic                q_push,
    output cmd_t                q_cmd
);

    logic trace_enable_reg;
    logic trace_enable_next;
    logic accept;
    logic keep;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        trace_enable_next = trace_enable_reg;
        if (cfg_valid) begin
            trace_enable_next = cfg_data[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trace_enable_reg <= 1'b1;
        end else begin
            trace_enable_reg <= trace_enable_next;
        end
    end

    // disabled records and unknown operations are dropped here
    always_comb begin
        case (s_tuser)
            OP_RECORD: keep = trace_enable_reg;
            OP_DUMP:   keep = 1'b1;
            OP_SEARCH: keep = 1'b1;
            default:   keep = 1'b0;
        endcase
    end

    assign q_push = accept && keep;

    always_comb begin
        q_cmd.is_query     = (s_tuser != OP_RECORD);
        q_cmd.is_search    = (s_tuser == OP_SEARCH);
        q_cmd.entry.tag    = s_tdata[31:0];
        q_cmd.entry.args[0] = s_tdata[63:32];
        q_cmd.entry.args[1] = s_tdata[95:64];
        q_cmd.entry.args[2] = s_tdata[127:96];
        q_cmd.entry.args[3] = s_tdata[159:128];
        q_cmd.entry.args[4] = s_tdata[191:160];
        q_cmd.entry.cpu    = s_tdata[199:192];
        q_cmd.entry.tstamp = s_tdata[231:200];
        q_cmd.sel          = s_tdata[234:232];
        q_cmd.match        = s_tdata[266:235];
    end

endmodule

// ===== rtl/core/ctb_cmd_q.sv =====
module ctb_cmd_q
    import ctb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t cmd_in,
    output logic full,
    output logic valid,
    input  logic pop,
    output cmd_t cmd_out
);

    localparam int QPW = $clog2(Q_DEPTH);
    localparam int QCW = $clog2(Q_DEPTH + 1);

    cmd_t           slot_reg [Q_DEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QPW-1:0] rd_ptr_next;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == QCW'(Q_DEPTH));
    assign valid   = (count_reg != '0);
    assign cmd_out = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== rtl/core/ctb_back.sv =====
module ctb_back
    import ctb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  cmd_t                q_cmd,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [0:0]          m_tuser,
    output logic                m_tlast
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_EV   = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    entry_t mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    entry_t           rd_entry_reg;
    logic             rd_vld_reg;

    logic [1:0]    state_reg,  state_next;
    logic [PW-1:0] wp_reg,     wp_next;
    logic [PW-1:0] slot_reg,   slot_next;
    logic [CW-1:0] cnt_reg,    cnt_next;
    logic          search_reg, search_next;
    logic [2:0]    sel_reg,    sel_next;
    logic [31:0]   match_reg,  match_next;
    logic          have_pend_reg, have_pend_next;
    entry_t        pend_entry_reg, pend_entry_next;
    logic [PW-1:0] pend_slot_reg,  pend_slot_next;

    logic          m_valid_reg, m_valid_next;
    logic          m_has_reg,   m_has_next;
    logic          m_last_reg,  m_last_next;
    logic [5:0]    m_slot_reg,  m_slot_next;
    entry_t        m_entry_reg, m_entry_next;

    logic        mem_we;
    logic        rd_en;
    logic        out_free;
    logic        rd_empty;
    logic [31:0] sel_arg;
    logic        sel_ok;
    logic        hit;

    assign out_free = !m_valid_reg || m_tready;
    assign rd_empty = !rd_vld_reg || (rd_entry_reg.tag == '0);

    always_comb begin
        sel_ok = 1'b1;
        case (sel_reg)
            3'd0:    sel_arg = rd_entry_reg.args[0];
            3'd1:    sel_arg = rd_entry_reg.args[1];
            3'd2:    sel_arg = rd_entry_reg.args[2];
            3'd3:    sel_arg = rd_entry_reg.args[3];
            3'd4:    sel_arg = rd_entry_reg.args[4];
            default: begin
                sel_arg = '0;
                sel_ok  = 1'b0;
            end
        endcase
    end

    assign hit = !rd_empty && (!search_reg || (sel_ok && (sel_arg == match_reg)));

    always_comb begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        search_next     = search_reg;
        sel_next        = sel_reg;
        match_next      = match_reg;
        have_pend_next  = have_pend_reg;
        pend_entry_next = pend_entry_reg;
        pend_slot_next  = pend_slot_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_has_next      = m_has_reg;
        m_last_next     = m_last_reg;
        m_slot_next     = m_slot_reg;
        m_entry_next    = m_entry_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        rd_en           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (!q_cmd.is_query) begin
                        mem_we  = 1'b1;
                        wp_next = (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;
                    end else begin
                        search_next    = q_cmd.is_search;
                        sel_next       = q_cmd.sel;
                        match_next     = q_cmd.match;
                        slot_next      = (wp_reg == '0) ? LAST_SLOT : wp_reg - 1'b1;
                        cnt_next       = '0;
                        have_pend_next = 1'b0;
                        state_next     = ST_RD;
                    end
                end
            end
            ST_RD: begin
                rd_en      = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_EV;
            end
            ST_EV: begin
                if (rd_empty) begin
                    state_next = ST_FIN;
                end else if (!(hit && have_pend_reg && !out_free)) begin
                    // a new hit releases the held one, which is then known not to be last
                    if (hit) begin
                        if (have_pend_reg) begin
                            m_valid_next = 1'b1;
                            m_has_next   = 1'b1;
                            m_last_next  = 1'b0;
                            m_slot_next  = 6'(pend_slot_reg);
                            m_entry_next = pend_entry_reg;
                        end
                        have_pend_next  = 1'b1;
                        pend_entry_next = rd_entry_reg;
                        pend_slot_next  = slot_reg;
                    end
                    if (cnt_reg == CW'(DEPTH)) begin
                        state_next = ST_FIN;
                    end else begin
                        slot_next  = (slot_reg == '0) ? LAST_SLOT : slot_reg - 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    m_has_next   = have_pend_reg;
                    m_slot_next  = have_pend_reg ? 6'(pend_slot_reg) : '0;
                    m_entry_next = have_pend_reg ? pend_entry_reg : '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            vld_reg       <= '0;
            have_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            have_pend_reg <= have_pend_next;
            m_valid_reg   <= m_valid_next;
            if (mem_we) begin
                vld_reg[wp_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg       <= slot_next;
        cnt_reg        <= cnt_next;
        search_reg     <= search_next;
        sel_reg        <= sel_next;
        match_reg      <= match_next;
        pend_entry_reg <= pend_entry_next;
        pend_slot_reg  <= pend_slot_next;
        m_has_reg      <= m_has_next;
        m_last_reg     <= m_last_next;
        m_slot_reg     <= m_slot_next;
        m_entry_reg    <= m_entry_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= q_cmd.entry;
        end
        if (rd_en) begin
            rd_entry_reg <= mem[slot_reg];
            rd_vld_reg   <= vld_reg[slot_reg];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_has_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_entry_reg.tstamp, m_entry_reg.cpu,
                       m_entry_reg.args[4], m_entry_reg.args[3], m_entry_reg.args[2],
                       m_entry_reg.args[1], m_entry_reg.args[0], m_entry_reg.tag,
                       m_slot_reg};

endmodule

// ===== rtl/core/circular_trace_buffer_top.sv =====
// Channel  Direction  Handshake             Payload
// s_       in         s_tvalid / s_tready   tuser: operation; tdata: event or query
// m_       out        m_tvalid / m_tready   tuser: has_entry; tlast: last_result
// cfg_     in         cfg_valid / cfg_ready cfg_data: trace_enable
//
// Records pass through a two-entry command queue and are written to the ring as they are popped,
// so a steady stream of records is taken at one per cycle while no dump or search is under way.
// A dump or search walks the ring on the single-port entry memory slot by slot from the newest,
// each slot taking a registered read (ST_RD), then a compare (ST_EV), and finishes in ST_FIN.
// Reset clears per-slot valid bits at once; no clearing pass is needed.
// A stalled result channel holds the walk; the input side keeps filling the queue.
module circular_trace_buffer_top
    import ctb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // msg_tag, arg_one, arg_two, arg_three, arg_four, arg_five, cpu_id, time_now,
    // arg_select, match_value
    input  logic [S_DATA_W-1:0] s_tdata,
    // operation
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // slot_index, out_tag, out_arg_one .. out_arg_five, out_cpu, out_time
    output logic [M_DATA_W-1:0] m_tdata,
    // has_entry
    output logic [0:0]          m_tuser,
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_data
);

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    cmd_t q_cmd_in;
    cmd_t q_cmd_out;

    ctb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd_in)
    );

    ctb_cmd_q u_cmd_q (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .cmd_in  (q_cmd_in),
        .full    (q_full),
        .valid   (q_valid),
        .pop     (q_pop),
        .cmd_out (q_cmd_out)
    );

    ctb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
